[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/fde_pkg.sv]
package fde_pkg;

  localparam int SAMPLE_W         = 8;
  localparam int FRAME_SIDE_W     = 7;
  localparam int MAX_SIDE_DEFAULT = 64;
  localparam logic [FRAME_SIDE_W-1:0] FRAME_SIDE_RESET = 7'd64;

  // per-item control from the front end to the difference stage
  typedef struct packed {
    logic take;
    logic warm;
  } diff_ctl_t;

endpackage

[rtl/frame_difference_encoder.sv]
// Compares each 8-bit sample with the one at the same place a frame earlier.
// One item is taken every clock while sample_stall is low; its result is
// offered from the output register, loaded from the frame store read and the
// registered sample once the output is free.
// The frame store is a single-port read-first memory of MAX_SIDE*MAX_SIDE
// entries, read and rewritten at the same address in the cycle an item is
// taken. No result is given for the first frame after reset or after a write
// of frame_side, which restarts the stream; frame_side is clamped to
// 1..MAX_SIDE. A stall on the result side holds the input once the pipe fills.
`include "assert_macros.svh"

module frame_difference_encoder #(
  parameter int MAX_SIDE = fde_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              frame_side_write,
  input  logic [fde_pkg::FRAME_SIDE_W-1:0]  frame_side,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic [fde_pkg::SAMPLE_W-1:0]      sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              changed,
  output logic [fde_pkg::SAMPLE_W-1:0]      magnitude,
  output logic                              negative
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = AW + 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int MW    = (SW > fde_pkg::FRAME_SIDE_W) ? SW : fde_pkg::FRAME_SIDE_W;

  logic [AW-1:0]                    position;
  logic                             warmed_up;
  logic [CW-1:0]                    frame_size;
  logic [CW-1:0]                    pos_inc;
  logic                             wrap;
  logic                             accept;
  logic [fde_pkg::FRAME_SIDE_W-1:0] side_src;
  logic [MW-1:0]                    side_ext;
  logic [SW-1:0]                    side;
  logic [CW-1:0]                    size_prod;
  logic [fde_pkg::SAMPLE_W-1:0]     rdata;
  logic                             busy;
  fde_pkg::diff_ctl_t               ctl;

  assign accept       = sample_valid && !busy;
  assign sample_stall = busy;
  assign pos_inc      = {1'b0, position} + CW'(1);
  assign wrap         = pos_inc >= frame_size;

  // frame size from the clamped side, worked out when the side is written or at reset
  always_comb begin
    side_src = rst ? fde_pkg::FRAME_SIDE_RESET : frame_side;
    side_ext = MW'(side_src);
    if (side_ext == '0) begin
      side = SW'(1);
    end else if (side_ext > MW'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(side_ext);
    end
    size_prod = CW'(side) * CW'(side);
  end

  always_ff @(posedge clk) begin
    if (rst || frame_side_write) begin
      frame_size <= size_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || frame_side_write) begin
      position  <= '0;
      warmed_up <= 1'b0;
    end else if (accept) begin
      position <= wrap ? '0 : pos_inc[AW-1:0];
      if (wrap) begin
        warmed_up <= 1'b1;
      end
    end
  end

  assign ctl.take = accept;
  assign ctl.warm = warmed_up;

  fde_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (accept),
    .addr  (position),
    .wdata (sample),
    .rdata (rdata)
  );

  fde_diff u_diff (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sample       (sample),
    .rdata        (rdata),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .changed      (changed),
    .magnitude    (magnitude),
    .negative     (negative)
  );

  `ASSERT_IMPLY(a_pos_in_frame, clk, rst, 1'b1, {1'b0, position} < frame_size)
  `ASSERT_NEXT(a_restart_cold, clk, rst, frame_side_write, !warmed_up && position == '0)

endmodule

[rtl/fde_store.sv]
module fde_store #(
  parameter int DEPTH = fde_pkg::MAX_SIDE_DEFAULT * fde_pkg::MAX_SIDE_DEFAULT,
  parameter int AW    = 12
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [AW-1:0]                 addr,
  input  logic [fde_pkg::SAMPLE_W-1:0]  wdata,
  output logic [fde_pkg::SAMPLE_W-1:0]  rdata
);

  logic [fde_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // single port, read-first: the old entry comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (en) begin
      mem[addr] <= wdata;
      rdata     <= mem[addr];
    end
  end

endmodule

[rtl/fde_diff.sv]
`include "assert_macros.svh"

module fde_diff (
  input  logic                          clk,
  input  logic                          rst,
  input  fde_pkg::diff_ctl_t            ctl,
  input  logic [fde_pkg::SAMPLE_W-1:0]  sample,
  input  logic [fde_pkg::SAMPLE_W-1:0]  rdata,
  output logic                          busy,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          changed,
  output logic [fde_pkg::SAMPLE_W-1:0]  magnitude,
  output logic                          negative
);

  logic                         s1_valid;
  logic [fde_pkg::SAMPLE_W-1:0] s1_sample;
  logic                         out_load;
  logic                         neg_next;

  assign out_load = s1_valid && (!result_valid || !result_stall);
  assign busy     = s1_valid && result_valid && result_stall;
  assign neg_next = rdata < s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctl.take) begin
      s1_valid <= ctl.warm;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      s1_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      changed   <= rdata != s1_sample;
      negative  <= neg_next;
      magnitude <= neg_next ? (s1_sample - rdata) : (rdata - s1_sample);
    end
  end

  // a blocked item must sit still until the output frees up
  `ASSERT_NEXT(a_s1_hold, clk, rst, busy, s1_valid && $stable(s1_sample))
  // an unchanged sample carries no difference
  `ASSERT_IMPLY(a_zero_diff, clk, rst, result_valid && !changed,
                magnitude == '0 && !negative)

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = fde_pkg::SAMPLE_W;
  localparam int FRAME_SIDE_W = fde_pkg::FRAME_SIDE_W;
  localparam int MAX_SIDE     = fde_pkg::MAX_SIDE_DEFAULT;
  localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int DRAIN        = 4;
  localparam int RAND_ITEMS   = 930;
  localparam int LIMIT        = 400000;

  typedef struct packed {
    logic                changed;
    logic [SAMPLE_W-1:0] magnitude;
    logic                negative;
  } diff_t;

  typedef enum logic {ROW_SAMPLE, ROW_SIDE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [SAMPLE_W-1:0] val;
    logic                typed;
    logic                has_res;
    logic                chg;
    logic [SAMPLE_W-1:0] mag;
    logic                neg;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    frame_side_write;
  logic [FRAME_SIDE_W-1:0] frame_side;
  logic                    sample_valid;
  logic                    sample_stall;
  logic [SAMPLE_W-1:0]     sample;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic                    changed;
  logic [SAMPLE_W-1:0]     magnitude;
  logic                    negative;

  frame_difference_encoder dut (
    .clk              (clk),
    .rst              (rst),
    .frame_side_write (frame_side_write),
    .frame_side       (frame_side),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .sample           (sample),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .changed          (changed),
    .magnitude        (magnitude),
    .negative         (negative)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model of the frame delay
  logic [SAMPLE_W-1:0]     last_frame [STORE_DEPTH];
  int unsigned             frame_pos;
  bit                      frame_full;
  logic [FRAME_SIDE_W-1:0] side_reg;

  diff_t       diff_q [$];
  int          errors;
  int          cycle_cnt;
  int unsigned samples_sent;
  int unsigned results_seen;
  int unsigned side_writes;
  logic        quiet;

  // no idling on either side through this window
  assign quiet = (cycle_cnt >= 500) && (cycle_cnt < 1000);

  // directed items; typed rows carry their result, the others go to the model
  dir_row_t dir_rows [25] = '{
    // reset side, still inside the first frame
    '{ROW_SAMPLE, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'hFF, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    // side 0 acts as 1: each item compares with the one before
    '{ROW_SIDE,   8'd0,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'hFF, 1'b1, 1'b1, 1'b1, 8'd255, 1'b1},
    '{ROW_SAMPLE, 8'h00, 1'b1, 1'b1, 1'b1, 8'd255, 1'b0},
    '{ROW_SAMPLE, 8'h00, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'h80, 1'b1, 1'b1, 1'b1, 8'd128, 1'b1},
    '{ROW_SAMPLE, 8'h7F, 1'b1, 1'b1, 1'b1, 8'd1,   1'b0},
    '{ROW_SAMPLE, 8'h7F, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'h55, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'hAA, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SIDE,   8'd1,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'h01, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'hFE, 1'b1, 1'b1, 1'b1, 8'd253, 1'b1},
    // 2x2 frame
    '{ROW_SIDE,   8'd2,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'd10, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'd20, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'd30, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'd40, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'd10, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'd25, 1'b1, 1'b1, 1'b1, 8'd5,   1'b1},
    '{ROW_SAMPLE, 8'd30, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_SAMPLE, 8'd35, 1'b1, 1'b1, 1'b1, 8'd5,   1'b0},
    '{ROW_SAMPLE, 8'hC3, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0}
  };

  function automatic int unsigned frame_area();
    int unsigned s;
    s = side_reg;
    if (s < 1) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s * s;
  endfunction

  task automatic diff_against_last_frame(input logic [SAMPLE_W-1:0] cur,
                                         output bit has_res, output diff_t d);
    int unsigned         area;
    logic [SAMPLE_W-1:0] prev;
    area = frame_area();
    if (frame_pos >= area) frame_pos = 0;
    has_res = frame_full;
    prev = last_frame[frame_pos];
    d.changed   = (prev != cur);
    d.negative  = (prev < cur);
    d.magnitude = d.negative ? cur - prev : prev - cur;
    last_frame[frame_pos] = cur;
    frame_pos++;
    if (frame_pos >= area) begin
      frame_pos  = 0;
      frame_full = 1'b1;
    end
  endtask

  // often repeats or near repeats of the stored sample, so unchanged cells are common
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned         r;
    logic [SAMPLE_W-1:0] old;
    old = last_frame[(frame_pos >= frame_area()) ? 0 : frame_pos];
    r = $urandom_range(99);
    if (!frame_full || r >= 50) return SAMPLE_W'($urandom);
    if (r < 30) return old;
    if (r < 40) return old + ($urandom_range(1) ? 8'd1 : 8'hFF);
    return $urandom_range(1) ? 8'h00 : 8'hFF;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit use_typed,
                             input bit typed_has, input diff_t typed_d);
    bit    taken;
    bit    has_res;
    diff_t d;
    while (!quiet && $urandom_range(99) < 27) begin
      sample_valid <= 1'b0;
      sample       <= SAMPLE_W'($urandom);
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !sample_stall;
    end
    samples_sent++;
    diff_against_last_frame(s, has_res, d);
    if (use_typed) begin
      has_res = typed_has;
      d       = typed_d;
    end
    if (has_res) diff_q.insert(diff_q.size(), d);
  endtask

  task automatic write_side(input logic [FRAME_SIDE_W-1:0] v);
    sample_valid <= 1'b0;
    while (diff_q.size() != 0) @(posedge clk);
    // items of a first frame give nothing back, so let the pipe empty
    repeat (DRAIN) @(posedge clk);
    frame_side_write <= 1'b1;
    frame_side       <= v;
    @(posedge clk);
    frame_side_write <= 1'b0;
    side_reg   = v;
    frame_pos  = 0;
    frame_full = 1'b0;
    side_writes++;
  endtask

  task automatic check_field(input string what, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_side
    diff_t want;
    if (!rst && result_valid && !result_stall) begin
      if (diff_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got changed %0b magnitude %0d negative %0b",
                 $time, changed, magnitude, negative);
        errors++;
      end else begin
        want = diff_q.pop_front();
        results_seen++;
        check_field("changed", SAMPLE_W'(want.changed), SAMPLE_W'(changed));
        check_field("magnitude", want.magnitude, magnitude);
        check_field("negative", SAMPLE_W'(want.negative), SAMPLE_W'(negative));
      end
    end
    result_stall <= !rst && !quiet && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, diff_q.size());
      $display("frame_difference_encoder test failed");
      $finish;
    end
  end

  initial begin : stimulus
    diff_t                   d;
    int unsigned             sel;
    int unsigned             area;
    int unsigned             n;
    int unsigned             rand_items;
    logic [FRAME_SIDE_W-1:0] side;
    samples_sent = 0;
    side_writes  = 0;
    rand_items   = 0;
    side_reg     = fde_pkg::FRAME_SIDE_RESET;
    frame_pos    = 0;
    frame_full   = 1'b0;
    rst              <= 1'b1;
    frame_side_write <= 1'b0;
    frame_side       <= fde_pkg::FRAME_SIDE_RESET;
    sample_valid     <= 1'b0;
    sample           <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SIDE) begin
        write_side(dir_rows[i].val[FRAME_SIDE_W-1:0]);
      end else begin
        d = '{changed: dir_rows[i].chg, magnitude: dir_rows[i].mag,
              negative: dir_rows[i].neg};
        send_sample(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].has_res, d);
      end
    end

    // an out of range side acts as 64, so nothing comes back yet; then a restart at 64
    write_side(7'd127);
    repeat (160) send_sample(pick_sample(), 1'b0, 1'b0, '0);
    write_side(FRAME_SIDE_W'(MAX_SIDE));
    repeat (40) send_sample(pick_sample(), 1'b0, 1'b0, '0);

    // small frames, some cut short before the first frame completes
    while (rand_items < RAND_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 15) side = FRAME_SIDE_W'($urandom_range(1));
      else if (sel < 70) side = FRAME_SIDE_W'($urandom_range(5, 2));
      else if (sel < 90) side = FRAME_SIDE_W'($urandom_range(10, 6));
      else side = FRAME_SIDE_W'($urandom_range(20, 11));
      write_side(side);
      area = frame_area();
      n = ($urandom_range(9) == 0) ? $urandom_range(area, 1) : area + $urandom_range(80, 1);
      if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
      repeat (n) send_sample(pick_sample(), 1'b0, 1'b0, '0);
      rand_items += n;
    end

    sample_valid <= 1'b0;
    while (diff_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d samples over %0d frame side writes (sides 0 to 20, 64 and 127)",
             samples_sent, side_writes);
    $display("checked %0d difference items, %0d errors", results_seen, errors);
    if (errors == 0) begin
      $display("frame_difference_encoder test passed");
    end else begin
      $display("frame_difference_encoder test failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/fde_pkg.sv
rtl/fde_store.sv
rtl/fde_diff.sv
rtl/frame_difference_encoder.sv
dv/tb.sv
